@@ rtl/tlmi_pkg.sv @@
// Shared constants, codes and types of the timed linear motion interpolator.
package tlmi_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int TIME_BITS_DEF  = 48;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int NUM_AXES      = 3;
  localparam int DUR_BITS      = 20;
  localparam int LIMIT_BITS    = 23;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 23;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_TIME  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_COORD_LIMIT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DUR     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DUR     = 2'd2;

  localparam logic [LIMIT_BITS-1:0] COORD_LIMIT_RST = 23'd5120000;
  localparam logic [DUR_BITS-1:0]   MIN_DUR_RST     = 20'd100;
  localparam logic [DUR_BITS-1:0]   MAX_DUR_RST     = 20'd60000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_LERP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_en;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/tlmi_div.sv @@
// Bit-serial restoring divider that forms the Q0.FRAC_BITS move fraction.
module tlmi_div import tlmi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DUR_BITS-1:0]  dividend,
  input  logic [DUR_BITS-1:0]  divisor,
  output div_stat_t            stat,
  output logic [FRAC_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

  logic [DUR_BITS-1:0] rem;
  logic [DUR_BITS-1:0] dsr;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [DUR_BITS:0]   shifted;
  logic [DUR_BITS:0]   diff;
  logic                take;

  // The remainder always stays below the divisor, so one compare and subtract
  // settles each quotient bit.
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dsr};
  assign take    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsr  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= take ? diff[DUR_BITS-1:0] : shifted[DUR_BITS-1:0];
      quot <= {quot[FRAC_BITS-2:0], take};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ rtl/tlmi_lane.sv @@
// One axis lane: endpoint range check, stored endpoints and the scaled interpolation.
module tlmi_lane import tlmi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lane_ctl_t                    ctl,
  input  logic [LIMIT_BITS-1:0]        coord_limit,
  input  logic signed [COORD_BITS-1:0] from_c,
  input  logic signed [COORD_BITS-1:0] to_c,
  input  logic [FRAC_BITS-1:0]         frac,
  output logic                         ok,
  output logic signed [COORD_BITS-1:0] origin,
  output logic signed [COORD_BITS-1:0] goal,
  output logic signed [COORD_BITS-1:0] pos
);

  localparam int MAG_BITS  = COORD_BITS + 1;
  localparam int CMP_BITS  = (MAG_BITS > LIMIT_BITS) ? MAG_BITS : LIMIT_BITS;
  localparam int PROD_BITS = COORD_BITS + FRAC_BITS + 2;

  logic [MAG_BITS-1:0]          from_ext;
  logic [MAG_BITS-1:0]          to_ext;
  logic [MAG_BITS-1:0]          from_mag;
  logic [MAG_BITS-1:0]          to_mag;
  logic signed [COORD_BITS:0]   delta;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [PROD_BITS-1:0]  step;

  assign from_ext = {from_c[COORD_BITS-1], from_c};
  assign to_ext   = {to_c[COORD_BITS-1], to_c};
  assign from_mag = from_c[COORD_BITS-1] ? (~from_ext + 1'b1) : from_ext;
  assign to_mag   = to_c[COORD_BITS-1] ? (~to_ext + 1'b1) : to_ext;

  assign ok = (CMP_BITS'(from_mag) <= CMP_BITS'(coord_limit)) &&
              (CMP_BITS'(to_mag) <= CMP_BITS'(coord_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      goal   <= '0;
    end else if (ctl.load) begin
      origin <= from_c;
      goal   <= to_c;
    end
  end

  assign delta = {goal[COORD_BITS-1], goal} - {origin[COORD_BITS-1], origin};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_BITS'(delta * $signed({1'b0, frac}));
    end
  end

  // An arithmetic shift floors toward minus infinity; the sum stays between
  // the two endpoints, so dropping the upper bits is exact.
  assign step = prod >>> FRAC_BITS;
  assign pos  = origin + step[COORD_BITS-1:0];

endmodule

@@ rtl/timed_linear_motion_interpolator.sv @@
// Top level of the three-axis timed linear motion interpolator.
//
// Usage: each request on the input channel (in_valid/in_ready) carries an
// action: start a move, sample the position at now_ms, or cancel the move.
// Every request gives exactly one result on the output channel
// (out_valid/out_ready) with a status, a position and moving/completed flags.
// Configuration registers (coordinate limit, shortest and longest duration)
// are written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
// always high and writes are meant to happen while no request is in flight.
// Start, cancel and samples that fall outside the move go from acceptance
// through the evaluation and output states to out_valid. A sample inside the
// move runs the bit-serial divider, one fraction bit per cycle, then a multiply
// step in the three axis lanes and an add step before the output state.
// One request is in flight at a time; in_ready rises once a result enters the
// output register, so a new request is not taken before the last one's result
// is registered. If the receiver stalls, the next request is still accepted
// and computed, and it waits in the sequencer until the output register frees.
// Synchronous reset empties both channels, clears the move, zeroes the stored
// endpoints and restores the configuration defaults.
module timed_linear_motion_interpolator import tlmi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   action,
  input  logic [TIME_BITS-1:0]         now_ms,
  input  logic signed [COORD_BITS-1:0] from_x,
  input  logic signed [COORD_BITS-1:0] from_y,
  input  logic signed [COORD_BITS-1:0] from_z,
  input  logic signed [COORD_BITS-1:0] to_x,
  input  logic signed [COORD_BITS-1:0] to_y,
  input  logic signed [COORD_BITS-1:0] to_z,
  input  logic [DUR_BITS-1:0]          move_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic signed [COORD_BITS-1:0] pos_z,
  output logic                         moving,
  output logic                         completed,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

  // Configuration registers.
  logic [LIMIT_BITS-1:0] coord_limit;
  logic [DUR_BITS-1:0]   min_duration;
  logic [DUR_BITS-1:0]   max_duration;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_limit  <= COORD_LIMIT_RST;
      min_duration <= MIN_DUR_RST;
      max_duration <= MAX_DUR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COORD_LIMIT: coord_limit  <= cfg_data[LIMIT_BITS-1:0];
        CFG_MIN_DUR:     min_duration <= cfg_data[DUR_BITS-1:0];
        CFG_MAX_DUR:     max_duration <= cfg_data[DUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The accepted request is held here while it is worked on.
  logic [1:0]                   item_action;
  logic [TIME_BITS-1:0]         item_now;
  logic signed [COORD_BITS-1:0] item_from [NUM_AXES];
  logic signed [COORD_BITS-1:0] item_to   [NUM_AXES];
  logic [DUR_BITS-1:0]          item_dur;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_action  <= action;
      item_now     <= now_ms;
      item_from[0] <= from_x;
      item_from[1] <= from_y;
      item_from[2] <= from_z;
      item_to[0]   <= to_x;
      item_to[1]   <= to_y;
      item_to[2]   <= to_z;
      item_dur     <= move_ms;
    end
  end

  // Move timing state; the endpoints live in the lanes.
  logic                 active;
  logic [TIME_BITS-1:0] begin_time;
  logic [TIME_BITS-1:0] end_time;
  logic [DUR_BITS-1:0]  span;

  state_t    state;
  state_t    state_next;
  lane_ctl_t lane_ctl;
  div_stat_t div_stat;
  logic      div_start;
  logic      out_load;

  logic [FRAC_BITS-1:0]         frac;
  logic [NUM_AXES-1:0]          lane_ok;
  logic signed [COORD_BITS-1:0] lane_origin [NUM_AXES];
  logic signed [COORD_BITS-1:0] lane_goal   [NUM_AXES];
  logic signed [COORD_BITS-1:0] lane_pos    [NUM_AXES];

  // The elapsed time is below the span whenever the divider runs, so its low
  // bits are the whole value.
  logic [TIME_BITS-1:0] elapsed;
  assign elapsed = item_now - begin_time;

  tlmi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed[DUR_BITS-1:0]),
    .divisor  (span),
    .stat     (div_stat),
    .quot     (frac)
  );

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    tlmi_lane #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctl         (lane_ctl),
      .coord_limit (coord_limit),
      .from_c      (item_from[i]),
      .to_c        (item_to[i]),
      .frac        (frac),
      .ok          (lane_ok[i]),
      .origin      (lane_origin[i]),
      .goal        (lane_goal[i]),
      .pos         (lane_pos[i])
    );
  end

  // Merge: the range verdicts of all lanes and the duration checks decide a
  // start; the finish time must not wrap past the top of the time range.
  logic [TIME_BITS:0] end_sum;
  logic               lim_ok;
  logic               dur_ok;
  logic               start_commit;
  logic               samp_interp;

  assign end_sum = {1'b0, item_now} + (TIME_BITS + 1)'(item_dur);
  assign lim_ok  = &lane_ok;
  assign dur_ok  = (item_dur >= min_duration) && (item_dur <= max_duration) &&
                   !end_sum[TIME_BITS];
  assign start_commit = (item_action == ACT_START) && lim_ok && dur_ok;
  assign samp_interp  = (item_action == ACT_SAMPLE) && active &&
                        (item_now > begin_time) && (item_now < end_time);

  // Result decided in the evaluation cycle; interpolated positions replace
  // the position later.
  logic [1:0]                   res_status;
  logic signed [COORD_BITS-1:0] res_pos [NUM_AXES];
  logic                         res_moving;
  logic                         res_completed;
  logic [1:0]                   res_status_next;
  logic signed [COORD_BITS-1:0] res_pos_next [NUM_AXES];
  logic                         res_moving_next;
  logic                         res_completed_next;
  logic                         finish_hit;

  always_comb begin
    res_status_next    = STAT_OK;
    res_moving_next    = 1'b0;
    res_completed_next = 1'b0;
    finish_hit         = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      res_pos_next[i] = '0;
    end
    case (item_action)
      ACT_START: begin
        if (!lim_ok) begin
          res_status_next = STAT_RANGE;
        end else if (!dur_ok) begin
          res_status_next = STAT_TIME;
        end
      end
      ACT_SAMPLE: begin
        if (!active) begin
          res_pos_next = lane_goal;
        end else if (item_now <= begin_time) begin
          res_pos_next    = lane_origin;
          res_moving_next = 1'b1;
        end else if (item_now >= end_time) begin
          res_pos_next       = lane_goal;
          res_completed_next = 1'b1;
          finish_hit         = 1'b1;
        end else begin
          res_moving_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      res_status    <= res_status_next;
      res_pos       <= res_pos_next;
      res_moving    <= res_moving_next;
      res_completed <= res_completed_next;
    end else if (state == ST_LERP) begin
      res_pos <= lane_pos;
    end
  end

  // Move state updates happen in the evaluation cycle only.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (state == ST_EVAL) begin
      if (start_commit) begin
        active <= 1'b1;
      end else if (finish_hit || item_action == ACT_CANCEL) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL && start_commit) begin
      begin_time <= item_now;
      end_time   <= end_sum[TIME_BITS-1:0];
      span       <= item_dur;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EVAL;
      ST_EVAL: state_next = samp_interp ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_stat.done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_LERP;
      ST_LERP: state_next = ST_OUT;
      ST_OUT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    lane_ctl  = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EVAL: begin
        lane_ctl.load = start_commit;
        div_start     = samp_interp;
      end
      ST_MUL: lane_ctl.mul_en = 1'b1;
      ST_OUT: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Output register: it parts the sequencer from a stalled receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= res_status;
      pos_x     <= res_pos[0];
      pos_y     <= res_pos[1];
      pos_z     <= res_pos[2];
      moving    <= res_moving;
      completed <= res_completed;
    end
  end

  // A result never reports a move both running and finished.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(moving && completed))
    else $error("moving and completed set together");

  // A rejected start carries no position and no flags.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_OK) |->
      (pos_x == '0 && pos_y == '0 && pos_z == '0 && !moving && !completed))
    else $error("rejected start carries position or flags");

  // The divider is never restarted while it is still iterating.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // Reset empties the output channel.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the three-axis timed linear motion interpolator.
module tb;
  import tlmi_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int TB = TIME_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;

  // Action code 3 is not decoded by the block; it must answer with all zeros.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Register index 3 is not mapped; a write to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  localparam logic [TB-1:0]       TIME_TOP = '1;
  localparam int unsigned         DUR_TOP = (1 << DUR_BITS) - 1;
  localparam int unsigned         LIM_TOP = (1 << LIMIT_BITS) - 1;
  localparam int                  HOLD_CYCLES = 400;
  localparam int                  REPORT_CAP = 100;

  // One request as it is presented on the input channel.
  typedef struct {
    logic [1:0]                   act;
    logic [TB-1:0]                now;
    logic signed [CB-1:0]         src [NUM_AXES];
    logic signed [CB-1:0]         dst [NUM_AXES];
    logic [DUR_BITS-1:0]          dur;
  } move_request_t;

  // One answer as it leaves on the output channel.
  typedef struct {
    logic [1:0]                   stat;
    logic signed [CB-1:0]         pos [NUM_AXES];
    logic                         moving;
    logic                         done;
  } position_reply_t;

  // The ledger keeps its own copy of the move and of the limit registers. Every
  // accepted request is turned into the answer the block owes, and answers are
  // matched in order against what comes out.
  class motion_ledger;
    logic [LIMIT_BITS-1:0] lim_q8;
    logic [DUR_BITS-1:0]   shortest_ms;
    logic [DUR_BITS-1:0]   longest_ms;
    longint                src_pt [NUM_AXES];
    longint                dst_pt [NUM_AXES];
    logic [TB-1:0]         t_begin;
    logic [TB-1:0]         t_end;
    bit                    running;
    position_reply_t       replies_due [$];
    int                    answered;
    int                    errors;

    function new();
      int i;
      lim_q8      = COORD_LIMIT_RST;
      shortest_ms = MIN_DUR_RST;
      longest_ms  = MAX_DUR_RST;
      for (i = 0; i < NUM_AXES; i++) begin
        src_pt[i] = 0;
        dst_pt[i] = 0;
      end
      t_begin  = '0;
      t_end    = '0;
      running  = 1'b0;
      answered = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_COORD_LIMIT: lim_q8 = data[LIMIT_BITS-1:0];
        CFG_MIN_DUR:     shortest_ms = data[DUR_BITS-1:0];
        CFG_MAX_DUR:     longest_ms = data[DUR_BITS-1:0];
        default: ;
      endcase
    endfunction

    function position_reply_t motion_reply(move_request_t rq);
      position_reply_t r;
      longint a [NUM_AXES];
      longint b [NUM_AXES];
      longint mag, frac, step;
      logic [TB-1:0] span, gone;
      bit fits;
      int i;
      r.stat   = STAT_OK;
      r.moving = 1'b0;
      r.done   = 1'b0;
      for (i = 0; i < NUM_AXES; i++) r.pos[i] = '0;
      fits = 1'b1;
      case (rq.act)
        ACT_START: begin
          for (i = 0; i < NUM_AXES; i++) begin
            a[i] = rq.src[i];
            b[i] = rq.dst[i];
            mag = (a[i] < 0) ? -a[i] : a[i];
            if (mag > lim_q8) fits = 1'b0;
            mag = (b[i] < 0) ? -b[i] : b[i];
            if (mag > lim_q8) fits = 1'b0;
          end
          // The endpoint check wins over the duration check.
          if (!fits) begin
            r.stat = STAT_RANGE;
          end else if (rq.dur < shortest_ms || rq.dur > longest_ms ||
                       rq.now > TIME_TOP - rq.dur) begin
            r.stat = STAT_TIME;
          end else begin
            for (i = 0; i < NUM_AXES; i++) begin
              src_pt[i] = a[i];
              dst_pt[i] = b[i];
            end
            t_begin = rq.now;
            t_end   = rq.now + rq.dur;
            running = 1'b1;
          end
        end
        ACT_SAMPLE: begin
          if (!running) begin
            for (i = 0; i < NUM_AXES; i++) r.pos[i] = CB'(dst_pt[i]);
          end else if (rq.now <= t_begin) begin
            for (i = 0; i < NUM_AXES; i++) r.pos[i] = CB'(src_pt[i]);
            r.moving = 1'b1;
          end else if (rq.now >= t_end) begin
            for (i = 0; i < NUM_AXES; i++) r.pos[i] = CB'(dst_pt[i]);
            r.done  = 1'b1;
            running = 1'b0;
          end else begin
            span = t_end - t_begin;
            gone = rq.now - t_begin;
            frac = (longint'(gone) << FB) / longint'(span);
            // An arithmetic shift of the signed product floors toward minus infinity.
            for (i = 0; i < NUM_AXES; i++) begin
              step = ((dst_pt[i] - src_pt[i]) * frac) >>> FB;
              r.pos[i] = CB'(src_pt[i] + step);
            end
            r.moving = 1'b1;
          end
        end
        ACT_CANCEL: running = 1'b0;
        default: ;
      endcase
      return r;
    endfunction

    function void log_request(move_request_t rq);
      replies_due.push_back(motion_reply(rq));
    endfunction

    task report(string msg);
      if (errors < REPORT_CAP) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_reply(position_reply_t got);
      position_reply_t want;
      int i;
      answered++;
      if (replies_due.size() == 0) begin
        report("answer arrived with no request outstanding");
        return;
      end
      want = replies_due.pop_front();
      if (got.stat !== want.stat)
        report($sformatf("answer %0d status %0d, wanted %0d", answered, got.stat, want.stat));
      for (i = 0; i < NUM_AXES; i++)
        if (got.pos[i] !== want.pos[i])
          report($sformatf("answer %0d axis %0d position %0d, wanted %0d",
                           answered, i, got.pos[i], want.pos[i]));
      if (got.moving !== want.moving)
        report($sformatf("answer %0d moving %0b, wanted %0b",
                         answered, got.moving, want.moving));
      if (got.done !== want.done)
        report($sformatf("answer %0d completed %0b, wanted %0b",
                         answered, got.done, want.done));
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   action;
  logic [TB-1:0]                now_ms;
  logic signed [CB-1:0]         from_x, from_y, from_z;
  logic signed [CB-1:0]         to_x, to_y, to_z;
  logic [DUR_BITS-1:0]          move_ms;
  logic                         out_valid;
  logic                         out_ready;
  logic [1:0]                   status;
  logic signed [CB-1:0]         pos_x, pos_y, pos_z;
  logic                         moving;
  logic                         completed;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_BITS-1:0]      cfg_index;
  logic [CFG_DATA_BITS-1:0]     cfg_data;

  motion_ledger book;
  int           issued = 0;

  // Stimulus-side copy of the limits, so that random moves can be shaped to pass
  // or to fail on purpose without racing the monitor.
  int unsigned  lim_now = COORD_LIMIT_RST;
  int unsigned  min_now = MIN_DUR_RST;
  int unsigned  max_now = MAX_DUR_RST;

  // steady switches random idling off on both sides; hold_start asks the
  // receiver for its one long hold-off.
  bit steady = 1'b0;
  bit hold_start = 1'b0;
  bit hold_done = 1'b0;

  timed_linear_motion_interpolator uut (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Generous guard against a hung handshake.
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [TB-1:0] wide48();
    return TB'({$urandom, $urandom});
  endfunction

  function automatic move_request_t mk(logic [1:0] a, logic [TB-1:0] t,
                                       int fx, int fy, int fz,
                                       int tx, int ty, int tz, int unsigned d);
    move_request_t rq;
    rq.act = a;
    rq.now = t;
    rq.src[0] = CB'(fx);
    rq.src[1] = CB'(fy);
    rq.src[2] = CB'(fz);
    rq.dst[0] = CB'(tx);
    rq.dst[1] = CB'(ty);
    rq.dst[2] = CB'(tz);
    rq.dur = DUR_BITS'(d);
    return rq;
  endfunction

  // A coordinate that passes the endpoint check, with the two limits favored.
  function automatic logic signed [CB-1:0] coord_inside(int unsigned lim);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return CB'(lim);
    if (pick == 1) return CB'(-int'(lim));
    return CB'(int'($urandom_range(0, 2 * lim)) - int'(lim));
  endfunction

  // A coordinate that fails the endpoint check; the most negative code never fits.
  function automatic logic signed [CB-1:0] coord_outside(int unsigned lim);
    int v;
    if (lim >= LIM_TOP || $urandom_range(0, 3) == 0) return CB'(-8388608);
    v = int'($urandom_range(lim + 1, LIM_TOP));
    return ($urandom_range(0, 1) == 1) ? CB'(-v) : CB'(v);
  endfunction

  function automatic move_request_t noise_request();
    move_request_t rq;
    int i;
    rq.act = 2'($urandom_range(0, 3));
    rq.now = wide48();
    for (i = 0; i < NUM_AXES; i++) begin
      rq.src[i] = CB'($urandom);
      rq.dst[i] = CB'($urandom);
    end
    rq.dur = DUR_BITS'($urandom);
    return rq;
  endfunction

  // A start request that mostly passes, and otherwise fails one check on purpose.
  function automatic move_request_t start_request();
    move_request_t rq;
    int unsigned fault;
    int i, axis;
    rq.act = ACT_START;
    for (i = 0; i < NUM_AXES; i++) begin
      rq.src[i] = coord_inside(lim_now);
      rq.dst[i] = coord_inside(lim_now);
    end
    rq.dur = DUR_BITS'($urandom_range(min_now, max_now));
    case ($urandom_range(0, 9))
      0, 1:    rq.now = TB'($urandom_range(0, 5000));
      2:       rq.now = TIME_TOP - rq.dur - TB'($urandom_range(0, 3));
      default: rq.now = wide48();
    endcase
    fault = $urandom_range(0, 99);
    if (fault < 6) begin
      axis = $urandom_range(0, NUM_AXES - 1);
      if ($urandom_range(0, 1) == 1) rq.src[axis] = coord_outside(lim_now);
      else rq.dst[axis] = coord_outside(lim_now);
    end else if (fault < 10 && min_now > 0) begin
      rq.dur = DUR_BITS'($urandom_range(0, min_now - 1));
    end else if (fault < 14 && max_now < DUR_TOP) begin
      rq.dur = DUR_BITS'($urandom_range(max_now + 1, DUR_TOP));
    end else if (fault < 18) begin
      // The finish time would run past the top of the clock.
      rq.now = TIME_TOP - rq.dur + TB'($urandom_range(1, 50));
    end
    return rq;
  endfunction

  // Sample times spread over before, at, inside, at the end of and after a move.
  function automatic logic [TB-1:0] sample_time(move_request_t mv);
    case ($urandom_range(0, 19))
      0, 1:    return mv.now - TB'($urandom_range(0, 2000));
      2, 3:    return mv.now;
      4, 5:    return mv.now + mv.dur;
      6, 7:    return mv.now + mv.dur + TB'($urandom_range(1, 100000));
      default: return mv.now + TB'($urandom_range(0, mv.dur));
    endcase
  endfunction

  // Offer one request and return at the edge where it is taken. Now and then the
  // sender first goes quiet for a while, so gaps land anywhere in the block's work.
  // Valid is left high on return, so back-to-back requests need no extra edge.
  task automatic send(move_request_t rq);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    action   <= rq.act;
    now_ms   <= rq.now;
    from_x   <= rq.src[0];
    from_y   <= rq.src[1];
    from_z   <= rq.src[2];
    to_x     <= rq.dst[0];
    to_y     <= rq.dst[1];
    to_z     <= rq.dst[2];
    move_ms  <= rq.dur;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
  endtask

  // Stop offering and wait until every request has been answered.
  task automatic settle();
    in_valid <= 1'b0;
    while (book.answered < issued) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all three limits, plus the unmapped index, while the block is idle.
  // Duration writes carry junk in the bits above the 20-bit field.
  task automatic load_limits(int unsigned lim, int unsigned mn, int unsigned mx);
    cfg_write(CFG_COORD_LIMIT, CFG_DATA_BITS'(lim));
    cfg_write(CFG_MIN_DUR, {3'($urandom_range(0, 7)), DUR_BITS'(mn)});
    cfg_write(CFG_MAX_DUR, {3'($urandom_range(0, 7)), DUR_BITS'(mx)});
    cfg_write(CFG_UNUSED, CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;
    lim_now = lim;
    min_now = mn;
    max_now = mx;
  endtask

  // Most of the random traffic is a start followed by a handful of samples of
  // that move, with cancels and restarts mixed in; the rest is raw noise.
  task automatic random_moves(int count);
    move_request_t mv, rq;
    int left, i, n;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 12) begin
        send(noise_request());
        left--;
      end else begin
        mv = start_request();
        send(mv);
        left--;
        n = $urandom_range(1, 8);
        for (i = 0; i < n && left > 0; i++) begin
          rq = mv;
          rq.act = ACT_SAMPLE;
          case ($urandom_range(0, 19))
            0: rq.act = ACT_CANCEL;
            1: begin
              mv = start_request();
              rq = mv;
            end
            default: rq.now = sample_time(mv);
          endcase
          send(rq);
          left--;
        end
      end
    end
  endtask

  // Monitor: at each edge, log an accepted request, check a delivered answer and
  // track register writes. All of these read values from before the edge.
  always @(posedge clk) begin : watch
    move_request_t   rq;
    position_reply_t rp;
    if (!rst) begin
      if (cfg_valid && cfg_ready) book.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        rq.act = action;
        rq.now = now_ms;
        rq.src[0] = from_x;
        rq.src[1] = from_y;
        rq.src[2] = from_z;
        rq.dst[0] = to_x;
        rq.dst[1] = to_y;
        rq.dst[2] = to_z;
        rq.dur = move_ms;
        book.log_request(rq);
      end
      if (out_valid && out_ready) begin
        rp.stat = status;
        rp.pos[0] = pos_x;
        rp.pos[1] = pos_y;
        rp.pos[2] = pos_z;
        rp.moving = moving;
        rp.done = completed;
        book.check_reply(rp);
      end
    end
  end

  // Receiver: short random stalls, none while steady is set, and one long
  // hold-off on request so that the block backs up into its input.
  initial begin : receiver
    int quiet_left;
    quiet_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet_left > 0) begin
        out_ready <= 1'b0;
        quiet_left--;
      end else if (!steady && $urandom_range(0, 99) == 0) begin
        out_ready <= 1'b0;
        quiet_left = $urandom_range(0, 19);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : main
    book = new();
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_START;
    now_ms = '0;
    from_x = '0;
    from_y = '0;
    from_z = '0;
    to_x = '0;
    to_y = '0;
    to_z = '0;
    move_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_COORD_LIMIT;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed checks under the reset limits. A sample right after reset finds
    // the move idle and must return the zeroed target; the unused action code
    // must answer with zeros.
    send(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_UNUSED, wide48(), -1, 7, 8388607, -8388608, 3, 4, DUR_TOP));
    // A move between the exact coordinate limits, sampled before, at, inside,
    // at the finish of and after the move.
    send(mk(ACT_START, 1000, 5120000, -5120000, 0, -5120000, 5120000, 12345, 100));
    send(mk(ACT_SAMPLE, 999, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SAMPLE, 1000, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SAMPLE, 1050, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SAMPLE, 1099, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SAMPLE, 1100, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SAMPLE, 1200, 0, 0, 0, 0, 0, 0, 0));
    // Endpoint just past the limit; an endpoint fault that also has a short
    // duration must report the endpoint; then both duration bounds.
    send(mk(ACT_START, 2000, 5120001, 0, 0, 0, 0, 0, 100));
    send(mk(ACT_START, 2000, 0, 0, 0, 0, 0, -8388608, 50));
    send(mk(ACT_START, 2000, 1, 2, 3, 4, 5, 6, 99));
    send(mk(ACT_START, 2000, 1, 2, 3, 4, 5, 6, 60001));
    // A move that ends exactly at the top of the clock, then one that would
    // overflow it and must leave the first move running.
    send(mk(ACT_START, TIME_TOP - 60000, -1, -256, 255, 1, 256, -255, 60000));
    send(mk(ACT_START, TIME_TOP - 59999, 9, 9, 9, 9, 9, 9, 60000));
    send(mk(ACT_SAMPLE, TIME_TOP - 30000, 0, 0, 0, 0, 0, 0, 0));
    // Restart while active, then cancel and sample the idle move.
    send(mk(ACT_START, 5000, 100, 200, 300, -7000, 0, 5000000, 60000));
    send(mk(ACT_SAMPLE, 35000, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_CANCEL, 36000, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SAMPLE, 40000, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_START, 0, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 1000));
    random_moves(150);
    settle();

    // Widest limits. A zero-length move completes on its first sample past the
    // start; a full-range longest move is sampled one millisecond before its end.
    load_limits(LIM_TOP, 0, DUR_TOP);
    send(mk(ACT_START, 77, -8388607, 8388607, -1, 8388607, -8388607, 1, 0));
    send(mk(ACT_SAMPLE, 77, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_SAMPLE, 78, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_START, 0, -8388607, -8388607, 8388607, 8388607, 8388607, -8388607,
            DUR_TOP));
    send(mk(ACT_SAMPLE, DUR_TOP - 1, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0));
    random_moves(100);
    // A stretch with neither side idling.
    steady = 1'b1;
    random_moves(100);
    steady = 1'b0;
    settle();

    // Narrowest limits: only the origin and zero-length moves pass.
    load_limits(0, 0, 0);
    random_moves(60);
    settle();

    // Random limits, with the receiver holding off long enough to fill the block.
    load_limits($urandom_range(1, LIM_TOP - 1), $urandom_range(0, 3000),
                $urandom_range(3000, 200000));
    hold_start = 1'b1;
    random_moves(200);
    settle();

    // Equal duration bounds and a small coordinate limit.
    load_limits(1000, 500, 500);
    random_moves(100);
    settle();

    // Fully random limits once more.
    load_limits($urandom_range(0, LIM_TOP), $urandom_range(0, 1000),
                $urandom_range(1000, DUR_TOP));
    random_moves(100);
    settle();

    // Leave room for any stray answer before judging the run.
    repeat (40) @(posedge clk);
    if (book.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
